// ----- hdl/slip_stick_contact_friction_top_assert.svh -----
// Assertion macros used by the slip-stick friction checker.
`ifndef SLIP_STICK_CONTACT_FRICTION_TOP_ASSERT_SVH
`define SLIP_STICK_CONTACT_FRICTION_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define SSC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off during reset.
`define SSC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/ssc_pkg.sv -----
// Types, constants and helpers for the slip-stick contact friction block.
package ssc_pkg;

  // Fixed-point format
  localparam int WB    = 32;
  localparam int FB    = 16;
  localparam int REG_W = 31;
  localparam int DIV_W = WB + FB;

  localparam logic signed [WB-1:0] WMAX = 32'sh7FFF_FFFF;
  localparam logic signed [WB-1:0] WMIN = 32'sh8000_0000;
  localparam logic signed [33:0]   W34_MAX = 34'sh0_7FFF_FFFF;
  localparam logic signed [33:0]   W34_MIN = 34'sh3_8000_0000;
  localparam logic [63:0]          NEG_LIM = 64'h0000_0000_8000_0000;

  // Register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_STOP_SPEED    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SPRING_STIFF  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STATIC_COEFF  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DYNAMIC_COEFF = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DAMP_TIME     = 3'd4;

  // Register reset values
  localparam logic [REG_W-1:0] RST_STOP_SPEED    = 31'd65536;
  localparam logic [REG_W-1:0] RST_SPRING_STIFF  = 31'd65536;
  localparam logic [REG_W-1:0] RST_STATIC_COEFF  = 31'd32768;
  localparam logic [REG_W-1:0] RST_DYNAMIC_COEFF = 31'd19661;
  localparam logic [REG_W-1:0] RST_DAMP_TIME     = 31'd0;

  typedef struct packed {
    logic [REG_W-1:0] stop_speed;
    logic [REG_W-1:0] spring_stiff;
    logic [REG_W-1:0] static_coeff;
    logic [REG_W-1:0] dynamic_coeff;
    logic [REG_W-1:0] damp_time;
  } cfg_t;

  typedef struct packed {
    logic [30:0]        normal_force;
    logic signed [31:0] normal_x;
    logic signed [31:0] normal_y;
    logic signed [31:0] normal_z;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
    logic signed [31:0] normal_speed;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
  } in_item_t;

  typedef struct packed {
    logic [30:0]        spring_energy;
    logic signed [31:0] force_x;
    logic signed [31:0] force_y;
    logic signed [31:0] force_z;
    logic               sticking;
  } out_item_t;

  // Shared unit operations
  typedef enum logic [1:0] {OP_MUL, OP_DIV, OP_ROOT} alu_op_e;

  typedef struct packed {
    logic               start;
    alu_op_e            op;
    logic [63:0]        opa;
    logic signed [31:0] opb;
  } alu_req_t;

  typedef struct packed {
    logic               done;
    logic signed [31:0] res;
    logic signed [63:0] prod;
  } alu_rsp_t;

  // Clamp a 34-bit signed value to the word
  function automatic logic signed [31:0] sat34(input logic signed [33:0] x);
    logic signed [31:0] r;
    if (x > W34_MAX) r = WMAX;
    else if (x < W34_MIN) r = WMIN;
    else r = x[31:0];
    return r;
  endfunction

endpackage

// ----- hdl/ssc_if.sv -----
// Request and result channel interfaces.
interface ssc_in_if;
  import ssc_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ssc_out_if;
  import ssc_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- hdl/ssc_alu.sv -----
// Shared multiply / divide / square-root unit.
module ssc_alu (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ssc_pkg::alu_req_t req_i,
  output ssc_pkg::alu_rsp_t rsp_o
);
  import ssc_pkg::*;

  typedef enum logic [1:0] {A_IDLE, A_MULP, A_DIV, A_ROOT} alu_st_e;

  alu_st_e            st_q;
  logic signed [63:0] prod_q;
  logic signed [31:0] res_q;
  logic               done_q;
  logic [DIV_W-1:0]   dvd_q, quo_q;
  logic [30:0]        rem_q;
  logic [31:0]        den_q;
  logic [63:0]        x_q, r_q, bit_q;
  logic [5:0]         cnt_q;

  // Multiply post-step: truncate toward zero, then clamp
  logic               neg;
  logic [63:0]        mag, sh;
  logic signed [31:0] mul_res;
  always_comb begin
    neg = prod_q[63];
    mag = neg ? 64'(-prod_q) : 64'(prod_q);
    sh  = mag >> FB;
    if (!neg) mul_res = (sh[63:31] != '0) ? WMAX : sh[31:0];
    else      mul_res = (sh > NEG_LIM) ? WMIN : -sh[31:0];
  end

  // Restoring divide, one quotient bit a cycle
  logic [31:0]      rem_sh;
  logic             dge;
  logic [30:0]      rem_nx;
  logic [DIV_W-1:0] quo_nx;
  always_comb begin
    rem_sh = {rem_q, dvd_q[DIV_W-1]};
    dge    = rem_sh >= den_q;
    rem_nx = dge ? 31'(rem_sh - den_q) : rem_sh[30:0];
    quo_nx = {quo_q[DIV_W-2:0], dge};
  end

  // Digit-by-digit root, one result bit a cycle
  logic [63:0] rb, x_nx, r_nx;
  logic        rge;
  always_comb begin
    rb   = r_q + bit_q;
    rge  = x_q >= rb;
    x_nx = rge ? x_q - rb : x_q;
    r_nx = rge ? (r_q >> 1) + bit_q : r_q >> 1;
  end

  // Sequencer of the unit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= A_IDLE;
      done_q <= 1'b0;
      res_q  <= '0;
      prod_q <= '0;
      dvd_q  <= '0;
      quo_q  <= '0;
      rem_q  <= '0;
      den_q  <= '0;
      x_q    <= '0;
      r_q    <= '0;
      bit_q  <= '0;
      cnt_q  <= '0;
    end else begin
      unique case (st_q)
        A_IDLE: begin
          done_q <= 1'b0;
          if (req_i.start) begin
            unique case (req_i.op)
              OP_MUL: begin
                prod_q <= $signed(req_i.opa[31:0]) * req_i.opb;
                st_q   <= A_MULP;
              end
              OP_DIV: begin
                dvd_q <= {req_i.opa[31:0], {FB{1'b0}}};
                quo_q <= '0;
                rem_q <= '0;
                den_q <= req_i.opb;
                cnt_q <= 6'(DIV_W - 1);
                st_q  <= A_DIV;
              end
              OP_ROOT: begin
                x_q   <= req_i.opa;
                r_q   <= '0;
                bit_q <= 64'h4000_0000_0000_0000;
                cnt_q <= 6'd31;
                st_q  <= A_ROOT;
              end
              default: ;
            endcase
          end
        end
        A_MULP: begin
          res_q  <= mul_res;
          done_q <= 1'b1;
          st_q   <= A_IDLE;
        end
        A_DIV: begin
          rem_q  <= rem_nx;
          quo_q  <= quo_nx;
          dvd_q  <= dvd_q << 1;
          cnt_q  <= cnt_q - 6'd1;
          done_q <= cnt_q == '0;
          if (cnt_q == '0) begin
            res_q <= (quo_nx[DIV_W-1:31] != '0) ? WMAX : quo_nx[31:0];
            st_q  <= A_IDLE;
          end
        end
        A_ROOT: begin
          x_q    <= x_nx;
          r_q    <= r_nx;
          bit_q  <= bit_q >> 2;
          cnt_q  <= cnt_q - 6'd1;
          done_q <= cnt_q == '0;
          if (cnt_q == '0) begin
            res_q <= (r_nx[63:31] != '0) ? WMAX : r_nx[31:0];
            st_q  <= A_IDLE;
          end
        end
        default: begin
          done_q <= 1'b0;
          st_q   <= A_IDLE;
        end
      endcase
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.res  = res_q;
  assign rsp_o.prod = prod_q;

endmodule

// ----- hdl/ssc_cfg.sv -----
// Configuration register file with write decode.
module ssc_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          we_i,
  input  logic [ssc_pkg::CFG_IDX_W-1:0] idx_i,
  input  logic [ssc_pkg::REG_W-1:0]     wdata_i,
  output ssc_pkg::cfg_t                 cfg_o
);
  import ssc_pkg::*;

  cfg_t cfg_q;

  // Unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.stop_speed    <= RST_STOP_SPEED;
      cfg_q.spring_stiff  <= RST_SPRING_STIFF;
      cfg_q.static_coeff  <= RST_STATIC_COEFF;
      cfg_q.dynamic_coeff <= RST_DYNAMIC_COEFF;
      cfg_q.damp_time     <= RST_DAMP_TIME;
    end else if (we_i) begin
      unique case (idx_i)
        CFG_STOP_SPEED:    cfg_q.stop_speed    <= wdata_i;
        CFG_SPRING_STIFF:  cfg_q.spring_stiff  <= wdata_i;
        CFG_STATIC_COEFF:  cfg_q.static_coeff  <= wdata_i;
        CFG_DYNAMIC_COEFF: cfg_q.dynamic_coeff <= wdata_i;
        CFG_DAMP_TIME:     cfg_q.damp_time     <= wdata_i;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- hdl/slip_stick_contact_friction_top.sv -----
// Slip-stick contact friction: sequencer, operand registers and output stage.
//
// Usage: one contact step per request on req_if (valid/ready). Each request
// gives one result on rsp_if. Registers must be written through cfg_we_i /
// cfg_idx_i / cfg_wdata_i only while no request is in flight; the block does
// not enforce this. Every step runs on one shared multiply/divide/root unit.
// One request is worked at a time; req ready is high only while the
// sequencer is idle.
// Reset: registers return to their defaults, the stick flag and anchor
// point clear, no result is pending.
// Stall: the result sits in an output register until taken; a new request
// is accepted meanwhile, and its result waits until the old one is gone.
module slip_stick_contact_friction_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  ssc_in_if.sink                        req_if,
  ssc_out_if.source                     rsp_if,
  input  logic                          cfg_we_i,
  input  logic [ssc_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [ssc_pkg::REG_W-1:0]     cfg_wdata_i
);
  import ssc_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_VT, S_SQ_VT, S_ROOT, S_DRIVE, S_DEN, S_PRE, S_ANC, S_U, S_UN,
    S_SQ_U, S_EN, S_DK, S_FK, S_FD, S_SQ_F, S_LIM, S_LSQ, S_SC, S_SF, S_DONE
  } seq_st_e;

  localparam logic [1:0] LAST_IDX = 2'd2;

  cfg_t     cfg;
  alu_req_t alu_req;
  alu_rsp_t alu_rsp;

  seq_st_e            st_q;
  logic               wait_q;
  logic [1:0]         idx_q;
  logic [30:0]        fn_q;
  logic signed [31:0] ns_q;
  logic signed [31:0] n_q [3];
  logic signed [31:0] v_q [3];
  logic signed [31:0] p_q [3];
  logic signed [31:0] vt_q [3];
  logic signed [31:0] u_q [3];
  logic signed [31:0] f_q [3];
  logic signed [31:0] anc_q [3];
  logic               flag_q;
  logic [63:0]        acc_q;
  logic signed [31:0] vtm_q, drive_q, t_q;
  logic signed [33:0] h_q, dacc_q;
  logic [30:0]        energy_q;
  logic               out_valid_q;
  out_item_t          out_q;

  ssc_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (cfg_we_i),
    .idx_i   (cfg_idx_i),
    .wdata_i (cfg_wdata_i),
    .cfg_o   (cfg)
  );

  ssc_alu u_alu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (alu_req),
    .rsp_o  (alu_rsp)
  );

  // Current vector elements and derived operands
  logic signed [31:0] n_cur, vt_cur, u_cur, uq_cur, f_cur;
  logic signed [31:0] k_s, mud_s, mus_s, damp_s, fn_s, usq_s, vtm_den;
  logic               last, stick_ok, rd_done;
  always_comb begin
    n_cur   = n_q[idx_q];
    vt_cur  = vt_q[idx_q];
    uq_cur  = u_q[idx_q];
    f_cur   = f_q[idx_q];
    u_cur   = sat34(34'(p_q[idx_q]) - 34'(anc_q[idx_q]));
    k_s     = {1'b0, cfg.spring_stiff};
    mud_s   = {1'b0, cfg.dynamic_coeff};
    mus_s   = {1'b0, cfg.static_coeff};
    damp_s  = {1'b0, cfg.damp_time};
    fn_s    = {1'b0, fn_q};
    usq_s   = (acc_q[63:FB+31] != '0) ? WMAX : {1'b0, acc_q[FB+30:FB]};
    vtm_den = (vtm_q < 32'sd1) ? 32'sd1 : vtm_q;
    last    = idx_q == LAST_IDX;
    stick_ok = (cfg.static_coeff != '0) && (vtm_q[30:0] <= cfg.stop_speed);
    rd_done = rsp_if.valid && rsp_if.ready;
  end

  // Operand selection for the shared unit
  logic signed [31:0] opa_lo;
  always_comb begin
    alu_req.start = (st_q != S_IDLE) && (st_q != S_DONE) && !wait_q;
    alu_req.op    = OP_MUL;
    opa_lo        = '0;
    alu_req.opb   = '0;
    unique case (st_q)
      S_VT:    begin opa_lo = ns_q;    alu_req.opb = n_cur;   end
      S_SQ_VT: begin opa_lo = vt_cur;  alu_req.opb = vt_cur;  end
      S_ROOT:  alu_req.op = OP_ROOT;
      S_DRIVE: begin opa_lo = mud_s;   alu_req.opb = fn_s;    end
      S_DEN:   begin opa_lo = k_s;     alu_req.opb = vtm_q;   end
      S_PRE:   begin
        alu_req.op = OP_DIV; opa_lo = drive_q; alu_req.opb = t_q;
      end
      S_ANC:   begin opa_lo = t_q;     alu_req.opb = vt_cur;  end
      S_U:     begin opa_lo = u_cur;   alu_req.opb = n_cur;   end
      S_UN:    begin opa_lo = t_q;     alu_req.opb = n_cur;   end
      S_SQ_U:  begin opa_lo = uq_cur;  alu_req.opb = uq_cur;  end
      S_EN:    begin opa_lo = k_s;     alu_req.opb = usq_s;   end
      S_DK:    begin opa_lo = damp_s;  alu_req.opb = k_s;     end
      S_FK:    begin opa_lo = k_s;     alu_req.opb = uq_cur;  end
      S_FD:    begin opa_lo = t_q;     alu_req.opb = vt_cur;  end
      S_SQ_F:  begin opa_lo = f_cur;   alu_req.opb = f_cur;   end
      S_LIM:   begin opa_lo = mus_s;   alu_req.opb = fn_s;    end
      S_LSQ:   begin opa_lo = t_q;     alu_req.opb = t_q;     end
      S_SC:    begin
        alu_req.op = OP_DIV; opa_lo = drive_q; alu_req.opb = vtm_den;
      end
      S_SF:    begin opa_lo = t_q;     alu_req.opb = vt_cur;  end
      default: ;
    endcase
    alu_req.opa = (st_q == S_ROOT) ? acc_q : {32'd0, opa_lo};
  end

  // Sequencer, operand registers, stick state and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= S_IDLE;
      wait_q      <= 1'b0;
      idx_q       <= '0;
      fn_q        <= '0;
      ns_q        <= '0;
      flag_q      <= 1'b0;
      acc_q       <= '0;
      vtm_q       <= '0;
      drive_q     <= '0;
      t_q         <= '0;
      h_q         <= '0;
      dacc_q      <= '0;
      energy_q    <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
      for (int i = 0; i < 3; i++) begin
        n_q[i]   <= '0;
        v_q[i]   <= '0;
        p_q[i]   <= '0;
        vt_q[i]  <= '0;
        u_q[i]   <= '0;
        f_q[i]   <= '0;
        anc_q[i] <= '0;
      end
    end else begin
      // output register: load a finished result, or drop a taken one
      if (st_q == S_DONE && (!out_valid_q || rd_done)) out_valid_q <= 1'b1;
      else if (rd_done) out_valid_q <= 1'b0;
      if (st_q == S_IDLE) begin
        if (req_if.valid) begin
          fn_q   <= req_if.data.normal_force;
          ns_q   <= req_if.data.normal_speed;
          n_q[0] <= req_if.data.normal_x;
          n_q[1] <= req_if.data.normal_y;
          n_q[2] <= req_if.data.normal_z;
          v_q[0] <= req_if.data.vel_x;
          v_q[1] <= req_if.data.vel_y;
          v_q[2] <= req_if.data.vel_z;
          p_q[0] <= req_if.data.point_x;
          p_q[1] <= req_if.data.point_y;
          p_q[2] <= req_if.data.point_z;
          idx_q  <= '0;
          acc_q  <= '0;
          st_q   <= S_VT;
        end
      end else if (st_q == S_DONE) begin
        if (!out_valid_q || rd_done) begin
          out_q.spring_energy <= energy_q;
          out_q.force_x       <= f_q[0];
          out_q.force_y       <= f_q[1];
          out_q.force_z       <= f_q[2];
          out_q.sticking      <= flag_q;
          st_q                <= S_IDLE;
        end
      end else if (!wait_q) begin
        wait_q <= 1'b1;
      end else if (alu_rsp.done) begin
        wait_q <= 1'b0;
        unique case (st_q)
          S_VT: begin
            vt_q[idx_q] <= sat34(34'(v_q[idx_q]) - 34'(alu_rsp.res));
            idx_q <= last ? 2'd0 : idx_q + 2'd1;
            if (last) st_q <= S_SQ_VT;
          end
          S_SQ_VT: begin
            acc_q <= acc_q + $unsigned(alu_rsp.prod);
            idx_q <= last ? 2'd0 : idx_q + 2'd1;
            if (last) st_q <= S_ROOT;
          end
          S_ROOT: begin
            vtm_q <= alu_rsp.res;
            st_q  <= S_DRIVE;
          end
          S_DRIVE: begin
            drive_q <= alu_rsp.res;
            idx_q   <= '0;
            dacc_q  <= '0;
            if (stick_ok) st_q <= flag_q ? S_U : S_DEN;
            else          st_q <= S_SC;
          end
          S_DEN: begin
            t_q  <= (alu_rsp.res < 32'sd1) ? 32'sd1 : alu_rsp.res;
            st_q <= S_PRE;
          end
          S_PRE: begin
            t_q  <= alu_rsp.res - damp_s;
            st_q <= S_ANC;
          end
          S_ANC: begin
            anc_q[idx_q] <= sat34(34'(p_q[idx_q]) - 34'(alu_rsp.res));
            idx_q <= last ? 2'd0 : idx_q + 2'd1;
            if (last) begin
              flag_q <= 1'b1;
              st_q   <= S_U;
            end
          end
          S_U: begin
            u_q[idx_q] <= u_cur;
            dacc_q <= dacc_q + 34'(alu_rsp.res);
            idx_q  <= last ? 2'd0 : idx_q + 2'd1;
            if (last) begin
              t_q  <= sat34(dacc_q + 34'(alu_rsp.res));
              st_q <= S_UN;
            end
          end
          S_UN: begin
            u_q[idx_q] <= sat34(34'(uq_cur) - 34'(alu_rsp.res));
            idx_q <= last ? 2'd0 : idx_q + 2'd1;
            if (last) begin
              acc_q <= '0;
              st_q  <= S_SQ_U;
            end
          end
          S_SQ_U: begin
            acc_q <= acc_q + $unsigned(alu_rsp.prod);
            idx_q <= last ? 2'd0 : idx_q + 2'd1;
            if (last) st_q <= S_EN;
          end
          S_EN: begin
            energy_q <= alu_rsp.res[31:1];
            st_q     <= S_DK;
          end
          S_DK: begin
            t_q   <= alu_rsp.res;
            idx_q <= '0;
            st_q  <= S_FK;
          end
          S_FK: begin
            h_q  <= -34'(alu_rsp.res);
            st_q <= S_FD;
          end
          S_FD: begin
            f_q[idx_q] <= sat34(h_q - 34'(alu_rsp.res));
            idx_q <= last ? 2'd0 : idx_q + 2'd1;
            if (last) begin
              acc_q <= '0;
              st_q  <= S_SQ_F;
            end else begin
              st_q  <= S_FK;
            end
          end
          S_SQ_F: begin
            acc_q <= acc_q + $unsigned(alu_rsp.prod);
            idx_q <= last ? 2'd0 : idx_q + 2'd1;
            if (last) st_q <= S_LIM;
          end
          S_LIM: begin
            t_q  <= alu_rsp.res;
            st_q <= S_LSQ;
          end
          S_LSQ: begin
            // force at or over the static limit breaks the stick
            st_q <= (acc_q >= $unsigned(alu_rsp.prod)) ? S_SC : S_DONE;
          end
          S_SC: begin
            flag_q   <= 1'b0;
            energy_q <= '0;
            t_q      <= alu_rsp.res;
            idx_q    <= '0;
            for (int i = 0; i < 3; i++) anc_q[i] <= '0;
            st_q     <= S_SF;
          end
          S_SF: begin
            f_q[idx_q] <= sat34(-34'(alu_rsp.res));
            idx_q <= last ? 2'd0 : idx_q + 2'd1;
            if (last) st_q <= S_DONE;
          end
          default: st_q <= S_IDLE;
        endcase
      end
    end
  end

  assign req_if.ready = st_q == S_IDLE;
  assign rsp_if.valid = out_valid_q;
  assign rsp_if.data  = out_q;

endmodule

// ----- hdl/ssc_chk.sv -----
// Port-level checker for the slip-stick friction block, bound to the top.
`include "slip_stick_contact_friction_top_assert.svh"

module ssc_chk (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input ssc_pkg::out_item_t  out_data
);
  import ssc_pkg::*;

  // One request at a time: busy right after a request is taken
  `SSC_ASSERT_NXT(a_busy_after_req, in_valid && in_ready, !in_ready, "ready after request")

  // Stalled result holds
  `SSC_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "result changed while stalled")

  // Slipping contact stores no energy
  `SSC_ASSERT_IMP(a_slip_no_energy, out_valid && !out_data.sticking, out_data.spring_energy == '0, "energy while slipping")

  // Energy is half a saturated product
  `SSC_ASSERT_IMP(a_energy_half, out_valid, !out_data.spring_energy[30], "energy over half range")

endmodule

bind slip_stick_contact_friction_top ssc_chk u_ssc_chk (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_valid  (req_if.valid),
  .in_ready  (req_if.ready),
  .out_valid (rsp_if.valid),
  .out_ready (rsp_if.ready),
  .out_data  (rsp_if.data)
);
